/* hdl/mrs_pkg.sv */
// types and constants shared by the mailbox request sequencer
package mrs_pkg;

  localparam int unsigned ArgSlots  = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;
  localparam logic [16:0] TickMax   = 17'h1FFFF;

  // mailbox status words
  localparam logic [31:0] MbxNotReady = 32'h0000_0000;
  localparam logic [31:0] MbxOk       = 32'h0000_0001;
  localparam logic [31:0] MbxInvalid  = 32'h0000_00FE;
  localparam logic [31:0] MbxFailed   = 32'h0000_00FF;

  // register reset values
  localparam logic [11:0] RstIndexOffset  = 12'h0C4;
  localparam logic [11:0] RstDataOffset   = 12'h0C8;
  localparam logic [31:0] RstMsgIdAddr    = 32'h03B1_0534;
  localparam logic [31:0] RstStatusAddr   = 32'h03B1_0980;
  localparam logic [31:0] RstDataBaseAddr = 32'h03B1_09E0;
  localparam logic [15:0] RstTimeoutTicks = 16'd500;

  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindStart = 2'd1,
    KindReply = 2'd2,
    KindTick  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActRead  = 2'd1,
    ActWord  = 2'd2,
    ActDone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StTimeout    = 3'd1,
    StInvalidMsg = 3'd2,
    StFailed     = 3'd3,
    StUnknown    = 3'd4,
    StBusError   = 3'd5
  } done_code_e;

  typedef enum logic [2:0] {
    CfgIndexOffset  = 3'd0,
    CfgDataOffset   = 3'd1,
    CfgMsgIdAddr    = 3'd2,
    CfgStatusAddr   = 3'd3,
    CfgDataBaseAddr = 3'd4,
    CfgTimeoutTicks = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhClrIdx  = 4'd1,
    PhClrDat  = 4'd2,
    PhArgIdx  = 4'd3,
    PhArgDat  = 4'd4,
    PhIdIdx   = 4'd5,
    PhIdDat   = 4'd6,
    PhPollIdx = 4'd7,
    PhPollRd  = 4'd8,
    PhRspIdx  = 4'd9,
    PhRspRd   = 4'd10
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        socket;
    logic [31:0] msg_id;
    logic [3:0]  arg_count;
    logic [3:0]  response_count;
    logic [2:0]  arg_index;
    logic [31:0] data;
    logic        bus_error;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        target_socket;
    logic [11:0] cfg_offset;
    logic [31:0] wdata;
    logic [31:0] response_word;
    logic [2:0]  response_index;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

endpackage

/* hdl/mailbox_request_sequencer_top.sv */
// mailbox request sequencer: step logic, argument store and result buffer
//
//   channel   | signals                         | beat
//   ----------+---------------------------------+-------------------------------
//   in        | in_valid_i/in_ready_o/in_data_i | load, start, bus reply or tick
//   out       | out_valid_o/out_ready_i/out_data_o | access, response word or done
//   cfg       | cfg_we_i/cfg_idx_i/cfg_data_i   | register write, no wait
//
// one input beat is taken per cycle; its state update and up to two result
// beats are formed in that cycle and land in a four-entry result buffer.
// in_ready_o drops while the buffer holds more than two beats, so input
// stalls only when the output side backs up.
// reset clears the sequencer, hung flags, counters and buffer at once; the
// argument store is not reset.
module mailbox_request_sequencer_top #(
  parameter int unsigned SOCKETS  = 2,
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mrs_pkg::req_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mrs_pkg::rsp_t out_data_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import mrs_pkg::*;

  localparam logic [3:0] MaxArgs = 4'(MAX_ARGS);

  // configuration
  logic [11:0] index_off_q, data_off_q;
  logic [31:0] msg_id_addr_q, status_addr_q, data_base_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_off_q   <= RstIndexOffset;
      data_off_q    <= RstDataOffset;
      msg_id_addr_q <= RstMsgIdAddr;
      status_addr_q <= RstStatusAddr;
      data_base_q   <= RstDataBaseAddr;
      timeout_q     <= RstTimeoutTicks;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgIndexOffset:  index_off_q   <= cfg_data_i[11:0];
        CfgDataOffset:   data_off_q    <= cfg_data_i[11:0];
        CfgMsgIdAddr:    msg_id_addr_q <= cfg_data_i;
        CfgStatusAddr:   status_addr_q <= cfg_data_i;
        CfgDataBaseAddr: data_base_q   <= cfg_data_i;
        CfgTimeoutTicks: timeout_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e        phase_q, phase_d;
  logic [SOCKETS-1:0] hung_q, hung_d;
  logic [3:0]    wc_q, wc_d;
  logic [16:0]   elapsed_q, elapsed_d;
  logic          sock_q, sock_d;
  logic [31:0]   msg_q, msg_d;
  logic [3:0]    argc_q, argc_d, rc_q, rc_d;
  logic [31:0]   arg_store [ArgSlots];

  logic          in_fire, out_fire, store_we;
  logic          emit_word, emit_done, emit_issue, hung_hit;
  done_code_e    done_code;
  logic [3:0]    argc_sat, rc_sat;
  logic [1:0]    n_res;
  rsp_t          word_res, next_res, res0, res1;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  assign argc_sat = (in_data_i.arg_count > MaxArgs) ? MaxArgs : in_data_i.arg_count;
  assign rc_sat   = (in_data_i.response_count > MaxArgs) ? MaxArgs : in_data_i.response_count;

  always_comb begin
    hung_hit = 1'b0;
    for (int i = 0; i < SOCKETS; i++) begin
      if (i == int'(in_data_i.socket)) hung_hit = hung_q[i];
    end
  end

  always_comb begin
    phase_d    = phase_q;
    hung_d     = hung_q;
    wc_d       = wc_q;
    elapsed_d  = elapsed_q;
    sock_d     = sock_q;
    msg_d      = msg_q;
    argc_d     = argc_q;
    rc_d       = rc_q;
    store_we   = 1'b0;
    emit_word  = 1'b0;
    emit_done  = 1'b0;
    emit_issue = 1'b0;
    done_code  = StOk;
    if (in_fire) begin
      case (kind_e'(in_data_i.kind))
        KindLoad: begin
          store_we = (phase_q == PhIdle);
        end
        KindStart: begin
          if (phase_q == PhIdle) begin
            sock_d    = in_data_i.socket;
            msg_d     = in_data_i.msg_id;
            argc_d    = argc_sat;
            rc_d      = rc_sat;
            wc_d      = '0;
            elapsed_d = '0;
            if (int'(in_data_i.socket) >= SOCKETS) begin
              emit_done = 1'b1;
              done_code = StBusError;
            end else if (hung_hit) begin
              emit_done = 1'b1;
              done_code = StTimeout;
            end else begin
              emit_issue = 1'b1;
              phase_d    = PhClrIdx;
            end
          end
        end
        KindReply: begin
          if (phase_q != PhIdle) begin
            if (in_data_i.bus_error) begin
              emit_done = 1'b1;
              done_code = StBusError;
            end else begin
              case (phase_q)
                PhClrIdx: begin
                  emit_issue = 1'b1;
                  phase_d    = PhClrDat;
                end
                PhClrDat: begin
                  wc_d       = '0;
                  emit_issue = 1'b1;
                  phase_d    = (argc_q != '0) ? PhArgIdx : PhIdIdx;
                end
                PhArgIdx: begin
                  emit_issue = 1'b1;
                  phase_d    = PhArgDat;
                end
                PhArgDat: begin
                  wc_d       = wc_q + 4'd1;
                  emit_issue = 1'b1;
                  phase_d    = (wc_d < argc_q) ? PhArgIdx : PhIdIdx;
                end
                PhIdIdx: begin
                  emit_issue = 1'b1;
                  phase_d    = PhIdDat;
                end
                PhIdDat: begin
                  elapsed_d  = '0;
                  emit_issue = 1'b1;
                  phase_d    = PhPollIdx;
                end
                PhPollIdx: begin
                  emit_issue = 1'b1;
                  phase_d    = PhPollRd;
                end
                PhPollRd: begin
                  if (in_data_i.data == MbxNotReady) begin
                    if (elapsed_q > {1'b0, timeout_q}) begin
                      for (int i = 0; i < SOCKETS; i++) begin
                        if (i == int'(sock_q)) hung_d[i] = 1'b1;
                      end
                      emit_done = 1'b1;
                      done_code = StTimeout;
                    end else begin
                      emit_issue = 1'b1;
                      phase_d    = PhPollIdx;
                    end
                  end else if (in_data_i.data == MbxInvalid) begin
                    emit_done = 1'b1;
                    done_code = StInvalidMsg;
                  end else if (in_data_i.data == MbxFailed) begin
                    emit_done = 1'b1;
                    done_code = StFailed;
                  end else if (in_data_i.data != MbxOk) begin
                    emit_done = 1'b1;
                    done_code = StUnknown;
                  end else begin
                    wc_d = '0;
                    if (rc_q == '0) begin
                      emit_done = 1'b1;
                      done_code = StOk;
                    end else begin
                      emit_issue = 1'b1;
                      phase_d    = PhRspIdx;
                    end
                  end
                end
                PhRspIdx: begin
                  emit_issue = 1'b1;
                  phase_d    = PhRspRd;
                end
                PhRspRd: begin
                  emit_word = 1'b1;
                  wc_d      = wc_q + 4'd1;
                  if (wc_d < rc_q) begin
                    emit_issue = 1'b1;
                    phase_d    = PhRspIdx;
                  end else begin
                    emit_done = 1'b1;
                    done_code = StOk;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        KindTick: begin
          if ((phase_q inside {PhPollIdx, PhPollRd}) && (elapsed_q < TickMax)) begin
            elapsed_d = elapsed_q + 17'd1;
          end
        end
        default: ;
      endcase
      if (emit_done) phase_d = PhIdle;
    end
  end

  // access or done beat that follows the step
  logic [31:0] word_addr;
  assign word_addr = data_base_q + {26'd0, wc_d, 2'b00};

  always_comb begin
    next_res               = '0;
    next_res.target_socket = sock_d;
    if (emit_done) begin
      next_res.action = ActDone;
      next_res.status = done_code;
    end else begin
      case (phase_d)
        PhClrIdx: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = index_off_q;
          next_res.wdata      = status_addr_q;
        end
        PhClrDat: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = data_off_q;
        end
        PhArgIdx, PhRspIdx: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = index_off_q;
          next_res.wdata      = word_addr;
        end
        PhArgDat: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = data_off_q;
          next_res.wdata      = arg_store[wc_d[2:0]];
        end
        PhIdIdx: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = index_off_q;
          next_res.wdata      = msg_id_addr_q;
        end
        PhIdDat: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = data_off_q;
          next_res.wdata      = msg_q;
        end
        PhPollIdx: begin
          next_res.action     = ActWrite;
          next_res.cfg_offset = index_off_q;
          next_res.wdata      = status_addr_q;
        end
        PhPollRd, PhRspRd: begin
          next_res.action     = ActRead;
          next_res.cfg_offset = data_off_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    word_res                = '0;
    word_res.action         = ActWord;
    word_res.target_socket  = sock_q;
    word_res.response_word  = in_data_i.data;
    word_res.response_index = wc_q[2:0];
  end

  // pack the beats of this step, last flag on the final one
  always_comb begin
    res0  = next_res;
    res1  = next_res;
    n_res = 2'd0;
    if (emit_word) begin
      res0      = word_res;
      res1.last = 1'b1;
      n_res     = 2'd2;
    end else if (emit_done || emit_issue) begin
      res0.last = 1'b1;
      n_res     = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hung_q    <= '0;
      wc_q      <= '0;
      elapsed_q <= '0;
      sock_q    <= 1'b0;
      msg_q     <= '0;
      argc_q    <= '0;
      rc_q      <= '0;
    end else begin
      phase_q   <= phase_d;
      hung_q    <= hung_d;
      wc_q      <= wc_d;
      elapsed_q <= elapsed_d;
      sock_q    <= sock_d;
      msg_q     <= msg_d;
      argc_q    <= argc_d;
      rc_q      <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) arg_store[in_data_i.arg_index] <= in_data_i.data;
  end

  // result buffer
  rsp_t              fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [FifoAw:0]   count_q;

  assign wr_ptr_nx   = wr_ptr_q + FifoAw'(1);
  assign in_ready_o  = (count_q <= (FifoAw+1)'(FifoDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wr_ptr_nx] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoAw'(n_res);
      if (out_fire) rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      count_q  <= count_q + (FifoAw+1)'(n_res) - (FifoAw+1)'(out_fire);
    end
  end

`ifndef SYNTHESIS
  // a hung socket stays hung
  a_hung_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hung_q & $past(hung_q)) == $past(hung_q))
    else $error("hung flag cleared");

  // the buffer never overflows
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FifoAw+1)'(FifoDepth))
    else $error("result buffer overflow");

  // word counter never runs past MaxArgs, the saturation limit of the counts
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= MaxArgs)
    else $error("word counter out of range");

  // an idle sequencer only leaves idle on a start beat
  a_start_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle && phase_d != PhIdle) |-> (in_fire && in_data_i.kind == KindStart))
    else $error("sequence launched without start");
`endif

endmodule
